// ===== rtl/tpq_pkg.sv =====
package tpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_W    = 16;
  localparam int PRIO_W      = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // per-slot verdict of the compare unit
  typedef struct packed {
    logic dup;
    logic take_free;
    logic take_best;
  } scan_hit_t;

endpackage

// ===== rtl/task_priority_queue_top.sv =====
// Bounded priority queue of up to 16 task handles. Push (tuser = 0) inserts a
// handle with its priority; pop (tuser = 1) removes the entry of highest
// priority, largest handle among equals. Every word in gives one word out.
// A push or pop walks the slots in ST_SCAN: one compare unit checks the
// slots one per cycle to find a duplicate and a free slot, or the best entry,
// and ST_FINISH then commits and loads the output register once it is free.
// A push with a null handle or a busy task skips the walk. The next word is
// taken while the previous result still waits in the output register.
module task_priority_queue_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // task_handle[15:0], task_priority[23:16], task_idle[24], zero[31:25]
  input  logic [tpq_pkg::IN_DATA_W-1:0]   s_tdata,
  // cmd[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ok[0], mark_queued[1], mark_idle[2], out_handle[18:3], out_priority[26:19],
  // entry_count[31:27]
  output logic [tpq_pkg::OUT_DATA_W-1:0]  m_tdata
);

  tpq_pkg::state_t state, state_next;

  logic [tpq_pkg::QUEUE_DEPTH-1:0] slot_valid;
  logic [tpq_pkg::HANDLE_W-1:0]    slot_handle [tpq_pkg::QUEUE_DEPTH];
  logic [tpq_pkg::PRIO_W-1:0]      slot_priority [tpq_pkg::QUEUE_DEPTH];
  logic [tpq_pkg::CNT_W-1:0]       count;

  logic [tpq_pkg::IDX_W-1:0]       idx;
  logic                            op_cmd;
  logic [tpq_pkg::HANDLE_W-1:0]    op_handle;
  logic [tpq_pkg::PRIO_W-1:0]      op_prio;
  logic                            dup;
  logic                            free_found;
  logic [tpq_pkg::IDX_W-1:0]       free_idx;
  logic                            best_found;
  logic [tpq_pkg::IDX_W-1:0]       best_idx;
  logic [tpq_pkg::HANDLE_W-1:0]    best_handle;
  logic [tpq_pkg::PRIO_W-1:0]      best_prio;

  logic [tpq_pkg::HANDLE_W-1:0]    in_handle;
  logic [tpq_pkg::PRIO_W-1:0]      in_prio;
  logic                            in_idle;
  logic                            in_accept;
  logic                            need_scan;
  logic                            last_idx;
  logic                            out_free;
  tpq_pkg::scan_hit_t              hit;

  assign in_handle = s_tdata[tpq_pkg::HANDLE_W-1:0];
  assign in_prio   = s_tdata[tpq_pkg::HANDLE_W +: tpq_pkg::PRIO_W];
  assign in_idle   = s_tdata[tpq_pkg::HANDLE_W + tpq_pkg::PRIO_W];

  assign s_tready  = (state == tpq_pkg::ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign need_scan = (s_tuser == tpq_pkg::CMD_POP) || ((in_handle != '0) && in_idle);
  assign last_idx  = (idx == tpq_pkg::IDX_W'(tpq_pkg::QUEUE_DEPTH - 1));
  assign out_free  = !m_tvalid || m_tready;

  tpq_cmp u_cmp (
    .cmd        (op_cmd),
    .req_handle (op_handle),
    .slot_v     (slot_valid[idx]),
    .slot_h     (slot_handle[idx]),
    .slot_p     (slot_priority[idx]),
    .free_found (free_found),
    .best_found (best_found),
    .best_h     (best_handle),
    .best_p     (best_prio),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tpq_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = need_scan ? tpq_pkg::ST_SCAN : tpq_pkg::ST_FINISH;
        end
      end
      tpq_pkg::ST_SCAN: begin
        if (last_idx) begin
          state_next = tpq_pkg::ST_FINISH;
        end
      end
      tpq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = tpq_pkg::ST_IDLE;
        end
      end
      default: state_next = tpq_pkg::ST_IDLE;
    endcase
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      dup        <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (in_accept) begin
      idx        <= '0;
      dup        <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (state == tpq_pkg::ST_SCAN) begin
      idx <= idx + 1'b1;
      if (hit.dup) begin
        dup <= 1'b1;
      end
      if (hit.take_free) begin
        free_found <= 1'b1;
      end
      if (hit.take_best) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_cmd    <= s_tuser;
      op_handle <= in_handle;
      op_prio   <= in_prio;
    end
    if (state == tpq_pkg::ST_SCAN) begin
      if (hit.take_free) begin
        free_idx <= idx;
      end
      if (hit.take_best) begin
        best_idx    <= idx;
        best_handle <= slot_handle[idx];
        best_prio   <= slot_priority[idx];
      end
    end
  end

  logic commit;
  logic do_insert;
  logic do_remove;

  assign commit    = (state == tpq_pkg::ST_FINISH) && out_free;
  assign do_insert = commit && (op_cmd == tpq_pkg::CMD_PUSH) && !dup && free_found;
  assign do_remove = commit && (op_cmd == tpq_pkg::CMD_POP) && best_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (do_insert) begin
      slot_valid[free_idx] <= 1'b1;
      count                <= count + 1'b1;
    end else if (do_remove) begin
      slot_valid[best_idx] <= 1'b0;
      count                <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      slot_handle[free_idx]   <= op_handle;
      slot_priority[free_idx] <= op_prio;
    end
  end

  logic [tpq_pkg::CNT_W-1:0] count_after;
  logic                      res_ok;
  logic                      res_mq;
  logic                      res_mi;

  always_comb begin
    count_after = count;
    if (do_insert) begin
      count_after = count + 1'b1;
    end else if (do_remove) begin
      count_after = count - 1'b1;
    end
  end

  assign res_ok = do_insert || do_remove;
  assign res_mq = (op_cmd == tpq_pkg::CMD_PUSH) && (dup || free_found);
  assign res_mi = do_remove;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {count_after,
                  do_remove ? best_prio   : {tpq_pkg::PRIO_W{1'b0}},
                  do_remove ? best_handle : {tpq_pkg::HANDLE_W{1'b0}},
                  res_mi, res_mq, res_ok};
    end
  end

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == 32'(count))
    else $error("entry count differs from occupied slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH))
    else $error("entry count above capacity");

  a_pop_nonnull: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> (m_tdata[18:3] != '0))
    else $error("pop returned a null handle");

endmodule

// ===== rtl/tpq_cmp.sv =====
module tpq_cmp (
  input  logic                         cmd,
  input  logic [tpq_pkg::HANDLE_W-1:0] req_handle,
  input  logic                         slot_v,
  input  logic [tpq_pkg::HANDLE_W-1:0] slot_h,
  input  logic [tpq_pkg::PRIO_W-1:0]   slot_p,
  input  logic                         free_found,
  input  logic                         best_found,
  input  logic [tpq_pkg::HANDLE_W-1:0] best_h,
  input  logic [tpq_pkg::PRIO_W-1:0]   best_p,
  output tpq_pkg::scan_hit_t           hit
);

  logic better;

  // priority first, larger handle breaks ties
  assign better = (slot_p > best_p) || ((slot_p == best_p) && (slot_h > best_h));

  always_comb begin
    hit = '0;
    unique case (cmd)
      tpq_pkg::CMD_PUSH: begin
        hit.dup       = slot_v && (slot_h == req_handle);
        hit.take_free = !slot_v && !free_found;
      end
      tpq_pkg::CMD_POP: begin
        hit.take_best = slot_v && (!best_found || better);
      end
      default: hit = '0;
    endcase
  end

endmodule
